// File: rtl/core/region_crc32_integrity_monitor_core_macros.svh
// Assertion macros for the region CRC-32 integrity monitor core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef REGION_CRC32_INTEGRITY_MONITOR_CORE_MACROS_SVH
`define REGION_CRC32_INTEGRITY_MONITOR_CORE_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define RCIM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define RCIM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rcim_pkg.sv
// Shared types, constants and the byte-wise CRC-32 step for the integrity monitor.
// No dependencies.
package rcim_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [6:0] VIOL_MAX = 7'd127;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] crc;
    logic [5:0]  idx;
    status_t     status;
    logic        is_check;
    logic        clr;
    logic        pass_done;
  } rcim_rec_t;

  typedef struct packed {
    logic [5:0]  region_index;
    logic [31:0] crc_value;
    logic [31:0] baseline_crc;
    logic        modified;
    logic [6:0]  violation_count;
    status_t     status;
    logic        pass_done;
  } rcim_res_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/rcim_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcim_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/rcim_queue.sv
// Short request queue between the front and back parts of the monitor.
// No dependencies.
module rcim_queue #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rcim_front.sv
// Front part: byte intake, running CRC, slot allocation and check sequencing.
// Depends on rcim_pkg; writes enrolled baselines into the RAM.
module rcim_front #(
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [7:0]          data_byte,
  input  logic                region_end,
  input  logic                pass_end,
  input  logic                q_full,
  output logic                q_push,
  output rcim_pkg::rcim_rec_t q_rec,
  output logic [ADDR_W-1:0]   q_addr,
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [31:0]         wr_data
);
  import rcim_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

  logic [31:0]      running_crc;
  logic [CNT_W-1:0] region_count;
  logic [CNT_W-1:0] check_position;
  logic [31:0]      crc_step;
  logic             accept;
  logic             room;
  logic             in_range;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign crc_step = crc32_byte(running_crc, data_byte);
  assign room     = (region_count < CNT_W'(MAX_REGIONS));
  assign in_range = (check_position < region_count);
  assign q_push   = accept && region_end;

  always_comb begin
    q_rec.crc       = crc_step ^ CRC_INIT;
    q_rec.is_check  = op;
    q_rec.clr       = op && (check_position == '0);
    q_rec.pass_done = op && pass_end;
    q_addr          = check_position[ADDR_W-1:0];
    if (!op) begin
      q_rec.idx    = room ? 6'(region_count) : 6'd0;
      q_rec.status = room ? ST_OK : ST_FULL;
    end else begin
      q_rec.idx    = 6'(check_position);
      q_rec.status = in_range ? ST_OK : ST_BEYOND;
    end
  end

  assign wr_en   = q_push && !op && room;
  assign wr_addr = region_count[ADDR_W-1:0];
  assign wr_data = crc_step ^ CRC_INIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= CRC_INIT;
      region_count   <= '0;
      check_position <= '0;
    end else if (accept) begin
      running_crc <= region_end ? CRC_INIT : crc_step;
      if (region_end) begin
        if (!op) begin
          if (room) begin
            region_count <= region_count + 1'b1;
          end
        end else if (pass_end) begin
          check_position <= '0;
        end else if (in_range) begin
          check_position <= check_position + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/rcim_back.sv
// Back part: baseline fetch, comparison, violation tally and result register.
// Depends on rcim_pkg; reads baselines from the RAM.
module rcim_back #(
  parameter int unsigned ADDR_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  rcim_pkg::rcim_rec_t q_rec,
  input  logic [ADDR_W-1:0]   q_addr,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  input  logic [31:0]         rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcim_pkg::rcim_res_t out_res
);
  import rcim_pkg::*;

  logic       s1_valid;
  rcim_rec_t  s1;
  logic       s1_move;
  logic       out_free;
  logic [6:0] violation_total;
  logic [6:0] vt_base;
  logic [6:0] violation_total_next;
  logic       mod;
  logic       ok;

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign q_pop    = !q_empty && (!s1_valid || s1_move);
  assign rd_en    = q_pop;
  assign rd_addr  = q_addr;

  assign ok      = (s1.status == ST_OK);
  assign mod     = s1.is_check && ok && (rd_data != s1.crc);
  assign vt_base = (s1.is_check && s1.clr) ? 7'd0 : violation_total;
  assign violation_total_next = (mod && vt_base != VIOL_MAX) ? vt_base + 7'd1 : vt_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      violation_total <= '0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid       <= 1'b1;
        violation_total <= violation_total_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_rec;
    end
    if (s1_move) begin
      out_res.region_index    <= s1.idx;
      out_res.crc_value       <= s1.crc;
      out_res.baseline_crc    <= !ok ? 32'd0 : (s1.is_check ? rd_data : s1.crc);
      out_res.modified        <= mod;
      out_res.violation_count <= violation_total_next;
      out_res.status          <= s1.status;
      out_res.pass_done       <= s1.pass_done;
    end
  end

endmodule

// File: rtl/core/region_crc32_integrity_monitor_core.sv
// Top level of the region CRC-32 integrity monitor: front, queue, baseline RAM, back.
// Depends on rcim_pkg, rcim_front, rcim_queue, rcim_ram, rcim_back and the macro header.
//
// Channel  Dir  tdata                               tuser               tlast
// s_axis   in   data_byte[7:0] pass_end[8]          op                  region_end
// m_axis   out  region_index crc baseline viol      modified status     pass_done
//
// One byte per cycle in while the queue has room; one result per region out.
// After the edge that accepts its last byte, a result passes through the queue,
// the RAM read and the result register before it is presented.
// The front stalls only when the four-entry queue is full; the back stalls on m_axis.
// rst is synchronous; the baseline table needs no clearing pass.
`include "region_crc32_integrity_monitor_core_macros.svh"

module region_crc32_integrity_monitor_core #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], pass_end[8], zero pad
  input  logic        s_axis_tuser,   // op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // region_index[5:0], crc_value[37:6],
                                      // baseline_crc[69:38], violation_count[76:70], pad
  output logic [2:0]  m_axis_tuser,   // modified[0], status[2:1]
  output logic        m_axis_tlast
);
  import rcim_pkg::*;

  localparam int unsigned ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned Q_W = $bits(rcim_rec_t) + ADDR_W;

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  rcim_rec_t         push_rec;
  rcim_rec_t         pop_rec;
  logic [ADDR_W-1:0] push_addr;
  logic [ADDR_W-1:0] pop_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;
  rcim_res_t         res;

  rcim_front #(.MAX_REGIONS(MAX_REGIONS), .ADDR_W(ADDR_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .data_byte  (s_axis_tdata[7:0]),
    .region_end (s_axis_tlast),
    .pass_end   (s_axis_tdata[8]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (push_rec),
    .q_addr     (push_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rcim_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_addr, push_rec}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  ({pop_addr, pop_rec})
  );

  rcim_ram #(.WIDTH(32), .DEPTH(MAX_REGIONS), .ADDR_W(ADDR_W)) u_baseline (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rcim_back #(.ADDR_W(ADDR_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rec     (pop_rec),
    .q_addr    (pop_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {3'b000, res.violation_count, res.baseline_crc, res.crc_value,
                         res.region_index};
  assign m_axis_tuser = {res.status, res.modified};
  assign m_axis_tlast = res.pass_done;

  `RCIM_ASSERT_IMP(a_full_zeroed, clk, rst,
    m_axis_tvalid && res.status == ST_FULL,
    res.region_index == 6'd0 && res.baseline_crc == 32'd0 && !res.modified,
    "table-full result carries a slot or baseline")
  `RCIM_ASSERT_IMP(a_clean_match, clk, rst,
    m_axis_tvalid && res.status == ST_OK && !res.modified,
    res.baseline_crc == res.crc_value,
    "unmodified result baseline differs from crc")
  `RCIM_ASSERT_IMP(a_mod_counted, clk, rst,
    m_axis_tvalid && res.modified,
    res.status == ST_OK && res.violation_count != 7'd0 && res.baseline_crc != res.crc_value,
    "modified result inconsistent with status or count")
  `RCIM_ASSERT_NXT(a_enroll_queued, clk, rst,
    wr_en,
    !q_empty,
    "enrolled region did not reach the queue")

endmodule

// File: tb/region_crc32_integrity_monitor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for region_crc32_integrity_monitor_core: streams enroll and
// check regions, predicts each per-region report and compares it field by field.
// Depends on rcim_pkg and the core RTL; needs no files or arguments.
module region_crc32_integrity_monitor_core_tb;
  import rcim_pkg::*;

  localparam int SLOTS = 64;
  localparam int SPAN = 16;
  localparam int QUIET_TAIL = 150;
  localparam int SINK_HOLD = 400;
  localparam int STALL_LIMIT = 4000;
  localparam logic OP_ENROLL = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       rend;
    logic       pend;
    bit         drain_first;
    bit         hold_sink;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  region_crc32_integrity_monitor_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] run_crc = CRC_INIT;
  logic [6:0]  enrolled = '0;
  logic [6:0]  check_slot = '0;
  logic [6:0]  viol_total = '0;
  logic [31:0] baselines [SLOTS];
  rcim_res_t   expected_reports [$];

  // stimulus generation state
  byte_req_t   byte_reqs [$];
  int          gen_count = 0;
  int          gen_chk = 0;
  logic [7:0]  cur_bytes [$];
  logic [7:0]  shadow_bytes [SLOTS][SPAN];
  int          shadow_len [SLOTS];
  bit          next_drain = 1'b0;
  bit          next_hold = 1'b0;

  // handshake bookkeeping
  int          next_req = 0;
  int          src_idle = 0;
  bit          head_hold = 1'b0;
  bit          req_taken = 1'b0;
  bit          quiet = 1'b0;
  int          accepted = 0;
  int          hold_grants = 0;
  int          hold_seen = 0;
  int          sink_hold_left = 0;
  int          sink_idle = 0;
  int          sink_cycles = 0;
  int          stall_cycles = 0;
  int          mismatches = 0;

  function automatic logic [31:0] crc32_advance(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  task automatic predict_request(input logic op, input logic [7:0] b, input logic rend,
                                 input logic pend);
    rcim_res_t   r;
    logic [31:0] crc;
    run_crc = crc32_advance(run_crc, b);
    if (rend) begin
      crc = ~run_crc;
      run_crc = CRC_INIT;
      r = '0;
      r.crc_value = crc;
      r.status = ST_OK;
      if (op == OP_ENROLL) begin
        if (enrolled < SLOTS) begin
          r.region_index = enrolled[5:0];
          baselines[enrolled[5:0]] = crc;
          r.baseline_crc = crc;
          enrolled++;
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        if (check_slot == 0) viol_total = '0;
        r.region_index = check_slot[5:0];
        if (check_slot < enrolled) begin
          r.baseline_crc = baselines[check_slot[5:0]];
          r.modified = (crc != r.baseline_crc);
          if (r.modified && viol_total < VIOL_MAX) viol_total++;
          check_slot++;
        end else begin
          r.status = ST_BEYOND;
        end
        if (pend) begin
          r.pass_done = 1'b1;
          check_slot = '0;
        end
      end
      r.violation_count = viol_total;
      expected_reports.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic compare_report();
    rcim_res_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("unexpected result", m_axis_tdata[37:6], 32'd0);
      return;
    end
    want = expected_reports.pop_front();
    if (m_axis_tdata[5:0] != want.region_index)
      report_mismatch("region_index", m_axis_tdata[5:0], want.region_index);
    if (m_axis_tdata[37:6] != want.crc_value)
      report_mismatch("crc_value", m_axis_tdata[37:6], want.crc_value);
    if (m_axis_tdata[69:38] != want.baseline_crc)
      report_mismatch("baseline_crc", m_axis_tdata[69:38], want.baseline_crc);
    if (m_axis_tdata[76:70] != want.violation_count)
      report_mismatch("violation_count", m_axis_tdata[76:70], want.violation_count);
    if (m_axis_tuser[2:1] != want.status)
      report_mismatch("status", m_axis_tuser[2:1], want.status);
    if (m_axis_tuser[0] != want.modified)
      report_mismatch("modified", m_axis_tuser[0], want.modified);
    if (m_axis_tlast != want.pass_done)
      report_mismatch("pass_done", m_axis_tlast, want.pass_done);
  endtask

  // queue one request and track table contents and check position for replay
  task automatic queue_byte(input logic op, input logic [7:0] b, input logic rend,
                            input logic pend);
    byte_req_t q;
    q.op = op;
    q.data = b;
    q.rend = rend;
    q.pend = pend;
    q.drain_first = next_drain;
    q.hold_sink = next_hold;
    next_drain = 1'b0;
    next_hold = 1'b0;
    byte_reqs.push_back(q);
    cur_bytes.push_back(b);
    if (rend) begin
      if (op == OP_ENROLL) begin
        if (gen_count < SLOTS) begin
          shadow_len[gen_count] = (cur_bytes.size() < SPAN) ? cur_bytes.size() : SPAN;
          for (int i = 0; i < shadow_len[gen_count]; i++)
            shadow_bytes[gen_count][i] = cur_bytes[i];
          gen_count++;
        end
      end else begin
        if (gen_chk < gen_count) gen_chk++;
        if (pend) gen_chk = 0;
      end
      cur_bytes.delete();
    end
  endtask

  task automatic gen_enroll_region();
    int len;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++)
      queue_byte((i == len - 1) ? OP_ENROLL : 1'($urandom_range(0, 1)), 8'($urandom),
                 (i == len - 1), 1'($urandom_range(0, 1)));
  endtask

  task automatic gen_check_region(input logic pend, input int mod_pct);
    logic [7:0] region_buf [SPAN];
    int         len;
    int         hit;
    if (gen_chk < gen_count) begin
      len = shadow_len[gen_chk];
      for (int i = 0; i < len; i++) region_buf[i] = shadow_bytes[gen_chk][i];
      if ($urandom_range(0, 99) < mod_pct) begin
        hit = $urandom_range(0, len - 1);
        region_buf[hit] = region_buf[hit] ^ 8'($urandom_range(1, 255));
      end
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) region_buf[i] = 8'($urandom);
    end
    for (int i = 0; i < len; i++)
      queue_byte((i == len - 1) ? OP_CHECK : 1'($urandom_range(0, 1)), region_buf[i],
                 (i == len - 1), (i == len - 1) ? pend : 1'($urandom_range(0, 1)));
  endtask

  task automatic gen_pass(input bit whole);
    int n;
    int mod_pct;
    mod_pct = $urandom_range(0, 4) * 25;
    n = gen_count - gen_chk;
    if (!whole && n > 1) n = $urandom_range(1, n - 1);
    if (n == 0) gen_check_region(1'b1, 0);
    else
      for (int k = 0; k < n; k++) gen_check_region(whole && k == n - 1, mod_pct);
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n)
      queue_byte(1'($urandom_range(0, 1)), 8'($urandom), ($urandom_range(0, 2) == 0),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic gen_mix();
    case ($urandom_range(0, 9))
      0, 1: gen_enroll_region();
      2, 3, 4, 5: gen_pass(1'b1);
      6: gen_pass(1'b0);
      7: gen_check_region(1'($urandom_range(0, 1)), 30);
      default: begin
        if ($urandom_range(0, 1) == 0) gen_noise();
        else gen_pass(1'b1);
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || req_taken)) begin
      if (src_idle > 0) begin
        src_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && ((accepted / 100) % 4) != 3 && $urandom_range(0, 9) == 0) begin
        src_idle = $urandom_range(0, 13);
        s_axis_tvalid <= 1'b0;
      end else if (next_req < byte_reqs.size() &&
                   !(byte_reqs[next_req].drain_first && expected_reports.size() != 0)) begin
        s_axis_tdata <= {7'd0, byte_reqs[next_req].pend, byte_reqs[next_req].data};
        s_axis_tuser <= byte_reqs[next_req].op;
        s_axis_tlast <= byte_reqs[next_req].rend;
        s_axis_tvalid <= 1'b1;
        head_hold = byte_reqs[next_req].hold_sink;
        next_req++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    sink_cycles++;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_grants) begin
      hold_seen = hold_grants;
      sink_hold_left = SINK_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_idle > 0) begin
      sink_idle--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && ((sink_cycles / 300) % 4) != 3 && $urandom_range(0, 7) == 0) begin
      sink_idle = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      req_taken = s_axis_tvalid && s_axis_tready;
      if (req_taken) begin
        predict_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[8]);
        accepted++;
        if (head_hold) hold_grants++;
      end
      if (m_axis_tvalid && m_axis_tready) compare_report();
      quiet = (byte_reqs.size() - next_req) < QUIET_TAIL;
      if (req_taken || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    queue_byte(OP_ENROLL, 8'h00, 1'b1, 1'b0);
    queue_byte(OP_ENROLL, 8'hFF, 1'b1, 1'b1);
    queue_byte(OP_CHECK,  8'h5A, 1'b0, 1'b1);
    queue_byte(OP_ENROLL, 8'hA5, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'h00, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'hFE, 1'b1, 1'b0);
    queue_byte(OP_ENROLL, 8'h5A, 1'b0, 1'b0);
    queue_byte(OP_CHECK,  8'hA5, 1'b1, 1'b1);
    queue_byte(OP_CHECK,  8'h00, 1'b1, 1'b0);
    queue_byte(OP_ENROLL, 8'h12, 1'b0, 1'b0);
    queue_byte(OP_ENROLL, 8'h34, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'hFF, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'h5A, 1'b0, 1'b0);
    queue_byte(OP_CHECK,  8'h00, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'h12, 1'b0, 1'b1);
    queue_byte(OP_CHECK,  8'h34, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'hFF, 1'b1, 1'b0);
    queue_byte(OP_CHECK,  8'h80, 1'b1, 1'b1);
    queue_byte(OP_CHECK,  8'h01, 1'b1, 1'b1);
    repeat (30) gen_enroll_region();
    next_hold = 1'b1;
    while (byte_reqs.size() < 650) gen_mix();
    next_drain = 1'b1;
    while (gen_count < SLOTS) gen_enroll_region();
    repeat (3) gen_enroll_region();
    gen_pass(1'b1);
    next_hold = 1'b1;
    while (byte_reqs.size() < 1150) gen_mix();

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (next_req < byte_reqs.size() || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rcim_pkg.sv
rtl/core/rcim_ram.sv
rtl/core/rcim_queue.sv
rtl/core/rcim_front.sv
rtl/core/rcim_back.sv
rtl/core/region_crc32_integrity_monitor_core.sv
tb/region_crc32_integrity_monitor_core_tb.sv
